// ===== design/tmpg_pkg.sv =====
`timescale 1ns / 1ps

package tmpg_pkg;

  // Screen and glyph geometry.
  localparam int TEXT_LINES   = 25;
  localparam int TEXT_COLUMNS = 80;
  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_HEIGHT = 16;

  localparam int CELL_COUNT  = TEXT_LINES * TEXT_COLUMNS;
  localparam int CELL_AW     = $clog2(CELL_COUNT);
  localparam int GLYPH_COUNT = 256 * GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
  localparam int FRAME_PIXELS = TEXT_LINES * GLYPH_HEIGHT * TEXT_COLUMNS * GLYPH_WIDTH;

  // The clearing pass after reset covers the larger of the two memories.
  localparam int CLEAR_LEN = (CELL_COUNT > GLYPH_COUNT) ? CELL_COUNT : GLYPH_COUNT;
  localparam int CLEAR_W   = $clog2(CLEAR_LEN);

  // Field widths.
  localparam int OPCODE_W = 2;
  localparam int LINE_W   = 6;
  localparam int COL_W    = 8;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int GROW_W   = 4;
  localparam int GCOL_W   = 3;
  localparam int COV_W    = 8;
  localparam int PIX_W    = 18;
  localparam int RGBA_W   = 32;
  localparam int CHAN_W   = 8;

  // Result queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Palette levels and channel select bits.
  localparam logic [CHAN_W-1:0] LEVEL_DIM  = 8'h7f;
  localparam logic [CHAN_W-1:0] LEVEL_FULL = 8'hff;
  localparam logic [CHAN_W-1:0] ALPHA      = 8'hff;
  localparam logic [2:0]        BIT_RED    = 3'b100;
  localparam logic [2:0]        BIT_GREEN  = 3'b010;
  localparam logic [2:0]        BIT_BLUE   = 3'b001;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE_CELL  = 2'd0,
    OP_WRITE_GLYPH = 2'd1,
    OP_RENDER      = 2'd2
  } op_e;

  // One entry of the cell memory: attribute in the upper byte.
  typedef struct packed {
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    logic [CHAR_W-1:0]  ch;
  } cell_t;

  typedef struct packed {
    logic              vld;
    logic [PIX_W-1:0]  pix;
    logic [GROW_W-1:0] grow;
    logic [GCOL_W-1:0] gcol;
  } lookup_t;

  typedef struct packed {
    logic               vld;
    logic [PIX_W-1:0]   pix;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } blend_req_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_index;
    logic [RGBA_W-1:0] pixel_rgba;
  } result_t;

  function automatic logic [CHAN_W-1:0] palette_channel(input logic [COLOR_W-1:0] entry,
                                                        input logic [2:0] sel);
    if ((entry[2:0] & sel) == 3'b000) begin
      return '0;
    end
    return entry[3] ? LEVEL_FULL : LEVEL_DIM;
  endfunction

  function automatic logic [GLYPH_AW-1:0] glyph_addr(input logic [CHAR_W-1:0] ch,
                                                     input logic [GROW_W-1:0] row,
                                                     input logic [GCOL_W-1:0] col);
    return GLYPH_AW'((32'(ch) * GLYPH_HEIGHT + 32'(row)) * GLYPH_WIDTH + 32'(col));
  endfunction

endpackage

// ===== design/tmpg_req_if.sv =====
`timescale 1ns / 1ps

interface tmpg_req_if;
  import tmpg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic signed [LINE_W-1:0]  line;
  logic signed [COL_W-1:0]   column;
  logic [CHAR_W-1:0]         char_code;
  logic [COLOR_W-1:0]        fg_color;
  logic [COLOR_W-1:0]        bg_color;
  logic [GROW_W-1:0]         glyph_row;
  logic [GCOL_W-1:0]         glyph_col;
  logic [COV_W-1:0]          coverage;

  modport source (
    output valid, opcode, line, column, char_code, fg_color, bg_color,
           glyph_row, glyph_col, coverage,
    input  ready
  );

  modport sink (
    input  valid, opcode, line, column, char_code, fg_color, bg_color,
           glyph_row, glyph_col, coverage,
    output ready
  );
endinterface

// ===== design/tmpg_rsp_if.sv =====
`timescale 1ns / 1ps

interface tmpg_rsp_if;
  import tmpg_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_index;
  logic [RGBA_W-1:0] pixel_rgba;

  modport source (
    output valid, pixel_index, pixel_rgba,
    input  ready
  );

  modport sink (
    input  valid, pixel_index, pixel_rgba,
    output ready
  );
endinterface

// ===== design/tmpg_ram.sv =====
`timescale 1ns / 1ps

module tmpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // A read and a write to the same entry in one cycle return the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/tmpg_blend.sv =====
`timescale 1ns / 1ps

module tmpg_blend (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tmpg_pkg::blend_req_t           req_i,
  input  logic [tmpg_pkg::COV_W-1:0]     cov_i,
  output logic                           res_valid_o,
  output tmpg_pkg::result_t              res_o
);
  import tmpg_pkg::*;

  localparam logic [2:0] CH_SEL [3] = '{BIT_RED, BIT_GREEN, BIT_BLUE};

  logic              vld_q;
  logic [PIX_W-1:0]  pix_q;
  logic [15:0]       num_d [3];
  logic [15:0]       num_q [3];
  logic [CHAN_W-1:0] chan  [3];

  // First half: from*255 + (to - from)*coverage for each channel.
  always_comb begin
    logic [CHAN_W-1:0] from_c;
    logic [CHAN_W-1:0] to_c;
    logic signed [8:0]  diff;
    logic signed [8:0]  cov_s;
    logic signed [17:0] base;
    logic signed [17:0] prod;
    for (int k = 0; k < 3; k++) begin
      from_c   = palette_channel(req_i.bg, CH_SEL[k]);
      to_c     = palette_channel(req_i.fg, CH_SEL[k]);
      diff     = $signed({1'b0, to_c}) - $signed({1'b0, from_c});
      cov_s    = $signed({1'b0, cov_i});
      base     = $signed(18'({from_c, 8'b0}) - 18'(from_c));
      prod     = 18'(diff) * 18'(cov_s);
      num_d[k] = 16'(base + prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= req_i.pix;
    for (int k = 0; k < 3; k++) begin
      num_q[k] <= num_d[k];
    end
  end

  // Second half: floor(n / 255) as (n + (n >> 8) + 1) >> 8, exact for n <= 255*255.
  always_comb begin
    logic [15:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum     = num_q[k] + (num_q[k] >> 8) + 16'd1;
      chan[k] = sum[15:8];
    end
  end

  assign res_valid_o       = vld_q;
  assign res_o.pixel_index = pix_q;
  assign res_o.pixel_rgba  = {chan[0], chan[1], chan[2], ALPHA};

endmodule

// ===== design/tmpg_out_fifo.sv =====
`timescale 1ns / 1ps

module tmpg_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tmpg_pkg::result_t  din_i,
  tmpg_rsp_if.source         rsp_o
);
  import tmpg_pkg::*;

  result_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;
  logic               pop;

  assign pop = rsp_o.valid && rsp_o.ready;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (FIFO_AW + 1)'(push_i) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

  assign rsp_o.valid       = (count_q != '0);
  assign rsp_o.pixel_index = mem_q[rd_ptr_q].pixel_index;
  assign rsp_o.pixel_rgba  = mem_q[rd_ptr_q].pixel_rgba;

endmodule

// ===== design/text_mode_pixel_generator.sv =====
`timescale 1ns / 1ps

// Text-mode pixel generator. Three kinds of request word arrive on req_i: write a
// character cell (character plus foreground and background palette index), write
// one coverage byte of a glyph, or render one pixel. A render whose cell and glyph
// position are in range returns one word on rsp_o carrying the linear frame index
// and an RGBA8888 colour blended from background to foreground by coverage / 255;
// writes and out-of-range renders return nothing. Negative line or column numbers
// count back from the bottom or right edge. The block takes one request word per
// clock for any mix of operations while req_i.ready is high; a render's result
// reaches the result queue after the cell memory read, the dependent glyph store
// read and the registered blend multiply. Results wait in an eight-word queue, and
// outside the clearing pass req_i.ready drops only while that queue, together with
// the renders still in flight, is full. After reset a clearing pass zeroes the cell
// memory and the glyph store over every entry of the larger one (the glyph store
// with the default geometry), and req_i.ready stays low for its whole length.

module text_mode_pixel_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmpg_req_if.sink   req_i,
  tmpg_rsp_if.source rsp_o
);
  import tmpg_pkg::*;

  localparam int LEW = LINE_W + 2;
  localparam int CEW = COL_W + 2;

  // Clearing pass.
  logic               clearing_q, clearing_d;
  logic [CLEAR_W-1:0] clr_q, clr_d;

  // Credit count: renders in flight plus words in the result queue.
  logic [FIFO_AW:0] credit_q, credit_d;

  logic accept;
  logic is_cell_wr, is_glyph_wr, is_render;

  // Address decode.
  logic signed [LEW-1:0] line_ext, line_adj;
  logic signed [CEW-1:0] col_ext, col_adj;
  logic [LEW-2:0]        line_u;
  logic [CEW-2:0]        col_u;
  logic                  cell_ok, glyph_ok, render_ok;
  logic [CELL_AW-1:0]    cell_idx;
  logic [PIX_W-1:0]      pix_idx;

  // Memory ports.
  logic                cell_we;
  logic [CELL_AW-1:0]  cell_waddr;
  cell_t               cell_wdata;
  cell_t               cell_rdata;
  logic                glyph_we;
  logic [GLYPH_AW-1:0] glyph_waddr;
  logic [COV_W-1:0]    glyph_wdata;
  logic [GLYPH_AW-1:0] glyph_raddr;
  logic [COV_W-1:0]    glyph_rdata;

  // Pipeline.
  lookup_t    s1_q, s1_d;
  blend_req_t s2_q, s2_d;
  logic       res_valid;
  result_t    res;

  assign accept = req_i.valid && req_i.ready;

  always_comb begin
    is_cell_wr  = 1'b0;
    is_glyph_wr = 1'b0;
    is_render   = 1'b0;
    unique case (req_i.opcode)
      OP_WRITE_CELL:  is_cell_wr  = 1'b1;
      OP_WRITE_GLYPH: is_glyph_wr = 1'b1;
      OP_RENDER:      is_render   = 1'b1;
      default: ;
    endcase
  end

  // A negative line or column has the screen size added once; anything still
  // outside the screen is dropped.
  always_comb begin
    line_ext = LEW'(req_i.line);
    col_ext  = CEW'(req_i.column);
    line_adj = (line_ext < 0) ? line_ext + LEW'(TEXT_LINES) : line_ext;
    col_adj  = (col_ext < 0) ? col_ext + CEW'(TEXT_COLUMNS) : col_ext;
    cell_ok  = (line_adj >= 0) && (line_adj < LEW'(TEXT_LINES)) &&
               (col_adj >= 0) && (col_adj < CEW'(TEXT_COLUMNS));
    glyph_ok = (32'(req_i.glyph_row) < GLYPH_HEIGHT) && (32'(req_i.glyph_col) < GLYPH_WIDTH);
    line_u   = line_adj[LEW-2:0];
    col_u    = col_adj[CEW-2:0];
    cell_idx = CELL_AW'(32'(line_u) * TEXT_COLUMNS + 32'(col_u));
    pix_idx  = PIX_W'((32'(line_u) * GLYPH_HEIGHT + 32'(req_i.glyph_row)) *
                      (GLYPH_WIDTH * TEXT_COLUMNS) +
                      32'(col_u) * GLYPH_WIDTH + 32'(req_i.glyph_col));
  end

  assign render_ok = accept && is_render && cell_ok && glyph_ok;

  // During the clearing pass both memories are written with zero, one entry a
  // clock; afterwards writes come straight from accepted request words. Writes
  // always land at the accept edge, so a later render's reads never see stale
  // data and an earlier render's reads are done before a later write lands.
  always_comb begin
    if (clearing_q) begin
      cell_we     = (32'(clr_q) < CELL_COUNT);
      cell_waddr  = CELL_AW'(clr_q);
      cell_wdata  = '0;
      glyph_we    = 1'b1;
      glyph_waddr = GLYPH_AW'(clr_q);
      glyph_wdata = '0;
    end else begin
      cell_we     = accept && is_cell_wr && cell_ok;
      cell_waddr  = cell_idx;
      cell_wdata  = '{bg: req_i.bg_color, fg: req_i.fg_color, ch: req_i.char_code};
      glyph_we    = accept && is_glyph_wr && glyph_ok;
      glyph_waddr = glyph_addr(req_i.char_code, req_i.glyph_row, req_i.glyph_col);
      glyph_wdata = req_i.coverage;
    end
  end

  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == CLEAR_W'(CLEAR_LEN - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_comb begin
    credit_d = credit_q + (FIFO_AW + 1)'(render_ok) -
               (FIFO_AW + 1)'(rsp_o.valid && rsp_o.ready);
  end

  assign req_i.ready = !clearing_q && (32'(credit_q) < FIFO_DEPTH);

  tmpg_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (CELL_COUNT)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_idx),
    .rdata_o (cell_rdata)
  );

  // Stage one: the cell word has been read; look up the glyph coverage byte.
  assign glyph_raddr = glyph_addr(cell_rdata.ch, s1_q.grow, s1_q.gcol);

  tmpg_ram #(
    .WIDTH (COV_W),
    .DEPTH (GLYPH_COUNT)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (glyph_waddr),
    .wdata_i (glyph_wdata),
    .raddr_i (glyph_raddr),
    .rdata_o (glyph_rdata)
  );

  always_comb begin
    s1_d.vld  = render_ok;
    s1_d.pix  = pix_idx;
    s1_d.grow = req_i.glyph_row;
    s1_d.gcol = req_i.glyph_col;

    s2_d.vld  = s1_q.vld;
    s2_d.pix  = s1_q.pix;
    s2_d.fg   = cell_rdata.fg;
    s2_d.bg   = cell_rdata.bg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      credit_q   <= '0;
      s1_q       <= '0;
      s2_q       <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
      credit_q   <= credit_d;
      s1_q       <= s1_d;
      s2_q       <= s2_d;
    end
  end

  // Stage two and three: blend with the coverage byte, then queue the result.
  tmpg_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (s2_q),
    .cov_i       (glyph_rdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tmpg_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .din_i  (res),
    .rsp_o  (rsp_o)
  );

endmodule

// ===== design/tmpg_checker.sv =====
`timescale 1ns / 1ps

module tmpg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic [tmpg_pkg::OPCODE_W-1:0]  req_opcode_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [tmpg_pkg::PIX_W-1:0]     rsp_index_i,
  input logic [tmpg_pkg::RGBA_W-1:0]    rsp_rgba_i
);
  import tmpg_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_index_i) && $stable(rsp_rgba_i))
    else $error("result word changed while stalled");

  // The clearing pass keeps the request side closed right after reset.
  assert property (@(posedge clk_i) $rose(rst_ni) |=> !req_ready_i)
    else $error("request accepted during clearing pass");

  // An empty queue only fills from a render accepted a fixed latency earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_valid_i && req_ready_i && req_opcode_i == OP_RENDER, 4))
    else $error("result word without a matching render");

  // Every result lies inside the frame and is opaque.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (32'(rsp_index_i) < FRAME_PIXELS) && (rsp_rgba_i[7:0] == ALPHA))
    else $error("result word outside frame or not opaque");

endmodule

bind text_mode_pixel_generator tmpg_checker u_tmpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_opcode_i (req_i.opcode),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_index_i  (rsp_o.pixel_index),
  .rsp_rgba_i   (rsp_o.pixel_rgba)
);
